// ===== src/slpd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the status LED pattern driver.
// No dependencies; imported by slpd_tick_step and the top level.
package slpd_pkg;

    localparam int ELAPSED_W = 10;
    localparam int QTR_W     = 2;
    localparam int FLASH_W   = 3;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 8;

    localparam logic [QTR_W-1:0]   QTR_LAST      = 2'd3;
    localparam logic [FLASH_W-1:0] FLASH_RED     = 3'd1;
    localparam logic [FLASH_W-1:0] FLASH_GREEN   = 3'd2;
    localparam logic [FLASH_W-1:0] FLASH_WRAP    = 3'd6;

    // node state codes
    localparam logic [1:0] NODE_INIT  = 2'd0;
    localparam logic [1:0] NODE_SETUP = 2'd1;
    localparam logic [1:0] NODE_RUN   = 2'd2;
    localparam logic [1:0] NODE_SLEEP = 2'd3;

    // one phase pattern: single flash, blink, flicker
    typedef struct packed {
        logic flash;
        logic blink;
        logic flicker;
    } t_pattern;

    localparam t_pattern PAT_ZERO = '{flash: 1'b0, blink: 1'b0, flicker: 1'b0};

endpackage

// ===== src/slpd_tick_step.sv =====
`timescale 1ns / 1ps
// Shared per-tick unit: compare and subtract the tick period, step the
// quarter and flash counters and form the next phase patterns. Uses slpd_pkg.
module slpd_tick_step #(
    parameter int TICK_MS = 50,
    parameter int ACC_W   = 11
) (
    input  logic [ACC_W-1:0]             i_acc,
    input  logic [slpd_pkg::QTR_W-1:0]   i_quarter,
    input  logic [slpd_pkg::FLASH_W-1:0] i_flash,
    input  slpd_pkg::t_pattern           i_red_pat,
    input  slpd_pkg::t_pattern           i_green_pat,
    output logic                         o_tick,
    output logic [ACC_W-1:0]             o_acc,
    output logic [slpd_pkg::QTR_W-1:0]   o_quarter,
    output logic [slpd_pkg::FLASH_W-1:0] o_flash,
    output slpd_pkg::t_pattern           o_red_pat,
    output slpd_pkg::t_pattern           o_green_pat
);
    import slpd_pkg::*;

    localparam logic [ACC_W-1:0] TICK_VAL = ACC_W'(TICK_MS);

    logic [FLASH_W-1:0] flash_inc;

    assign o_tick    = (i_acc >= TICK_VAL);
    assign o_acc     = i_acc - TICK_VAL;
    assign flash_inc = i_flash + FLASH_W'(1);

    always_comb begin
        o_red_pat   = PAT_ZERO;
        o_green_pat = PAT_ZERO;
        o_flash     = i_flash;
        if (i_quarter == QTR_LAST) begin
            // fourth tick: fresh pattern, toggle blink, step the flash
            o_quarter         = '0;
            o_red_pat.blink   = ~i_red_pat.blink;
            o_green_pat.blink = i_red_pat.blink;
            o_red_pat.flash   = (flash_inc == FLASH_RED);
            o_green_pat.flash = (flash_inc == FLASH_GREEN);
            o_flash           = (flash_inc >= FLASH_WRAP) ? '0 : flash_inc;
        end else begin
            // keep stored blink and flash bits
            o_quarter         = i_quarter + QTR_W'(1);
            o_red_pat.blink   = i_red_pat.blink;
            o_red_pat.flash   = i_red_pat.flash;
            o_green_pat.blink = i_green_pat.blink;
            o_green_pat.flash = i_green_pat.flash;
        end
        o_red_pat.flicker   = ~i_red_pat.flicker;
        o_green_pat.flicker = i_red_pat.flicker;
    end

endmodule

// ===== src/status_led_pattern_driver_core.sv =====
`timescale 1ns / 1ps
// Status LED pattern driver: one item in, at most one pin-level item out.
// Each item steps N ticks, N <= 21 at TICK_MS = 50, one tick per cycle on
// the single tick unit; an item without a tick gives no result. A new item
// is taken only in idle, once the last one has been emitted, which can wait
// on the output. Reset clears accumulator, counters and patterns.
module status_led_pattern_driver_core #(
    parameter int TICK_MS = 50
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [9:0] elapsed_ms, [11:10] node_state, [12] bus_off, [13] bus_warning,
    // [14] sensor_error, [15] hardware_failure
    input  logic [slpd_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // [0] red_pin_level, [1] green_pin_level, [7:2] zero
    output logic [slpd_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import slpd_pkg::*;

    // accumulator holds leftover (< TICK_MS) plus one capped elapsed value
    localparam int ACC_W = $clog2(TICK_MS + 1023);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [QTR_W-1:0]   r_quarter, n_quarter;
    logic [FLASH_W-1:0] r_flash, n_flash;
    t_pattern           r_red_pat, n_red_pat;
    t_pattern           r_green_pat, n_green_pat;
    t_pattern           r_work_red, n_work_red;
    t_pattern           r_work_green, n_work_green;
    logic               r_ticked, n_ticked;
    logic               r_out_valid, n_out_valid;
    logic               r_red_level, n_red_level;
    logic               r_green_level, n_green_level;

    // payload of the item at work
    logic [1:0]         r_node_state;
    logic               r_bus_off, r_bus_warning, r_sensor_error, r_hw_failure;

    logic               step_tick;
    logic [ACC_W-1:0]   step_acc;
    logic [QTR_W-1:0]   step_quarter;
    logic [FLASH_W-1:0] step_flash;
    t_pattern           step_red, step_green;

    logic               in_accept;
    logic               red_on, green_on;

    slpd_tick_step #(
        .TICK_MS (TICK_MS),
        .ACC_W   (ACC_W)
    ) u_tick_step (
        .i_acc       (r_acc),
        .i_quarter   (r_quarter),
        .i_flash     (r_flash),
        .i_red_pat   (r_red_pat),
        .i_green_pat (r_green_pat),
        .o_tick      (step_tick),
        .o_acc       (step_acc),
        .o_quarter   (step_quarter),
        .o_flash     (step_flash),
        .o_red_pat   (step_red),
        .o_green_pat (step_green)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // red priority: bus-off, hardware failure, warning, sensor error
    always_comb begin
        if (r_bus_off) begin
            red_on = 1'b1;
        end else if (r_hw_failure) begin
            red_on = r_red_pat.flicker;
        end else if (r_bus_warning) begin
            red_on = r_red_pat.flash;
        end else if (r_sensor_error) begin
            red_on = r_red_pat.blink;
        end else begin
            red_on = 1'b0;
        end
    end

    always_comb begin
        case (r_node_state)
            NODE_SLEEP: begin
                green_on = r_green_pat.flash;
            end
            NODE_SETUP: begin
                green_on = r_green_pat.flicker;
            end
            NODE_RUN: begin
                green_on = 1'b1;
            end
            default: begin
                green_on = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_acc         = r_acc;
        n_quarter     = r_quarter;
        n_flash       = r_flash;
        n_red_pat     = r_red_pat;
        n_green_pat   = r_green_pat;
        n_work_red    = r_work_red;
        n_work_green  = r_work_green;
        n_ticked      = r_ticked;
        n_out_valid   = r_out_valid;
        n_red_level   = r_red_level;
        n_green_level = r_green_level;

        // drop the result once the sink takes it
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_acc    = r_acc + ACC_W'(i_s_axis_tdata[ELAPSED_W-1:0]);
                    n_ticked = 1'b0;
                    n_state  = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step_tick) begin
                    // one tick per cycle; patterns read the stored values
                    n_acc        = step_acc;
                    n_quarter    = step_quarter;
                    n_flash      = step_flash;
                    n_work_red   = step_red;
                    n_work_green = step_green;
                    n_ticked     = 1'b1;
                end else if (r_ticked) begin
                    // last tick decides the new pattern
                    n_red_pat   = r_work_red;
                    n_green_pat = r_work_green;
                    n_state     = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid   = 1'b1;
                    n_red_level   = ~red_on;
                    n_green_level = ~green_on;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_quarter   <= '0;
            r_flash     <= '0;
            r_red_pat   <= PAT_ZERO;
            r_green_pat <= PAT_ZERO;
            r_ticked    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_quarter   <= n_quarter;
            r_flash     <= n_flash;
            r_red_pat   <= n_red_pat;
            r_green_pat <= n_green_pat;
            r_ticked    <= n_ticked;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_work_red    <= n_work_red;
        r_work_green  <= n_work_green;
        r_red_level   <= n_red_level;
        r_green_level <= n_green_level;
        if (in_accept) begin
            r_node_state   <= i_s_axis_tdata[11:10];
            r_bus_off      <= i_s_axis_tdata[12];
            r_bus_warning  <= i_s_axis_tdata[13];
            r_sensor_error <= i_s_axis_tdata[14];
            r_hw_failure   <= i_s_axis_tdata[15];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_W-2){1'b0}}, r_green_level, r_red_level};

endmodule

// ===== tb/sv/status_led_pattern_driver_core_checker.sv =====
`timescale 1ns / 1ps
// Checker for status_led_pattern_driver_core: it watches both streams, predicts the pin levels
// and compares each result as it leaves the block. Depends on slpd_pkg.
module status_led_pattern_driver_core_checker #(
    parameter int TICK_MS = 50
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    input  logic                         i_s_axis_tready,
    // [9:0] elapsed_ms, [11:10] node_state, [12] bus_off, [13] bus_warning,
    // [14] sensor_error, [15] hardware_failure
    input  logic [slpd_pkg::IN_W-1:0]    i_s_axis_tdata,
    input  logic                         i_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // [0] red_pin_level, [1] green_pin_level, [7:2] zero
    input  logic [slpd_pkg::OUT_W-1:0]   i_m_axis_tdata,
    output int                           o_fail_count,
    output int                           o_pending
);
    import slpd_pkg::*;

    // Predicted indicator state
    int                 acc_ms;
    logic [QTR_W-1:0]   qtr_pos;
    logic [FLASH_W-1:0] flash_pos;
    t_pattern           red_phase;
    t_pattern           green_phase;

    logic [OUT_W-1:0]   pin_levels_due[$];
    int                 fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    // Advance the tick phases by one item; emitted is set when the item saw a tick.
    task automatic advance_indicator_phases(input logic [IN_W-1:0] item, output bit emitted,
                                            output logic [OUT_W-1:0] levels);
        t_pattern rd;
        t_pattern gr;
        bit       red_lit;
        bit       green_lit;
        rd = PAT_ZERO;
        gr = PAT_ZERO;
        emitted = 1'b0;
        levels = '0;
        acc_ms += int'(item[ELAPSED_W-1:0]);
        while (acc_ms >= TICK_MS) begin
            emitted = 1'b1;
            acc_ms -= TICK_MS;
            if (qtr_pos == QTR_LAST) begin
                // fourth tick: rebuild blink and flash from scratch
                qtr_pos = '0;
                rd = PAT_ZERO;
                gr = PAT_ZERO;
                if (!red_phase.blink) rd.blink = 1'b1;
                else gr.blink = 1'b1;
                flash_pos++;
                if (flash_pos == FLASH_RED) rd.flash = 1'b1;
                else if (flash_pos == FLASH_GREEN) gr.flash = 1'b1;
                else if (flash_pos >= FLASH_WRAP) flash_pos = '0;
            end else begin
                qtr_pos++;
                rd = red_phase;
                gr = green_phase;
                rd.flicker = 1'b0;
                gr.flicker = 1'b0;
            end
            // flicker always reads the pattern stored before this item
            if (!red_phase.flicker) rd.flicker = 1'b1;
            else gr.flicker = 1'b1;
        end
        if (emitted) begin
            red_phase = rd;
            green_phase = gr;
            if (item[12]) red_lit = 1'b1;
            else if (item[15]) red_lit = rd.flicker;
            else if (item[13]) red_lit = rd.flash;
            else if (item[14]) red_lit = rd.blink;
            else red_lit = 1'b0;
            case (item[11:10])
                NODE_SLEEP: green_lit = gr.flash;
                NODE_SETUP: green_lit = gr.flicker;
                NODE_RUN:   green_lit = 1'b1;
                default:    green_lit = 1'b0;
            endcase
            levels[0] = !red_lit;
            levels[1] = !green_lit;
        end
    endtask

    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        logic [OUT_W-1:0] fresh;
        bit               emitted;
        if (!i_rst_n) begin
            acc_ms = 0;
            qtr_pos = '0;
            flash_pos = '0;
            red_phase = PAT_ZERO;
            green_phase = PAT_ZERO;
            pin_levels_due.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (pin_levels_due.size() == 0) begin
                    report_mismatch("unexpected result", int'(i_m_axis_tdata), -1);
                end else begin
                    want = pin_levels_due.pop_front();
                    if (i_m_axis_tdata[0] !== want[0])
                        report_mismatch("red_pin_level", int'(i_m_axis_tdata[0]), int'(want[0]));
                    if (i_m_axis_tdata[1] !== want[1])
                        report_mismatch("green_pin_level", int'(i_m_axis_tdata[1]),
                                        int'(want[1]));
                    if (i_m_axis_tdata[OUT_W-1:2] !== '0)
                        report_mismatch("padding", int'(i_m_axis_tdata[OUT_W-1:2]), 0);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                advance_indicator_phases(i_s_axis_tdata, emitted, fresh);
                if (emitted) pin_levels_due.push_back(fresh);
            end
        end
        o_pending <= pin_levels_due.size();
    end

endmodule

// ===== tb/sv/status_led_pattern_driver_core_test.sv =====
`timescale 1ns / 1ps
// Test top for status_led_pattern_driver_core: drives directed and random items with
// random gaps on both streams; depends on slpd_pkg, the block and its checker.
module status_led_pattern_driver_core_test;
    import slpd_pkg::*;

    localparam int TICK_MS     = 50;
    localparam int RANDOM_ITEMS = 1750;
    localparam int CYCLE_LIMIT = 600000;
    localparam int GAP_PCT     = 22;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    int                fail_count;
    int                pending;
    int                cycles = 0;
    bit                gaps_on = 1'b1;

    always #6 i_clk = ~i_clk;

    status_led_pattern_driver_core #(.TICK_MS(TICK_MS)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    status_led_pattern_driver_core_checker #(.TICK_MS(TICK_MS)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Stall the result side at random while gaps are enabled.
    always @(posedge i_clk) begin
        m_tready <= !gaps_on || ($urandom_range(0, 99) >= GAP_PCT);
    end

    // Bound the run in case the block hangs.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [IN_W-1:0] pack_item(input int elapsed, input logic [1:0] node,
                                                   input bit boff, input bit bwarn,
                                                   input bit serr, input bit hwf);
        return {hwf, serr, bwarn, boff, node, elapsed[ELAPSED_W-1:0]};
    endfunction

    // Hold valid for one item until it is taken; insert random gaps first.
    task automatic send_item(input logic [IN_W-1:0] item);
        while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= item;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    initial begin
        int         elapsed;
        int         pick;
        logic [1:0] node;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: no tick, exact tick, largest elapsed value in one item, red priority.
        send_item(pack_item(0, NODE_INIT, 0, 0, 0, 0));
        send_item(pack_item(49, NODE_RUN, 0, 0, 0, 0));
        send_item(pack_item(1, NODE_SETUP, 0, 0, 0, 1));
        send_item(pack_item(50, NODE_SLEEP, 0, 1, 0, 0));
        send_item(pack_item(50, NODE_RUN, 0, 0, 1, 0));
        send_item(pack_item(50, NODE_INIT, 1, 1, 1, 1));
        send_item(pack_item(1023, NODE_SLEEP, 0, 1, 0, 0));
        send_item(pack_item(1023, NODE_SETUP, 0, 1, 1, 1));
        send_item(pack_item(27, NODE_RUN, 0, 1, 1, 0));
        send_item(pack_item(1022, NODE_INIT, 0, 0, 0, 0));
        // four ticks per item steps the flash counter through its wrap
        for (int k = 0; k < 8; k++)
            send_item(pack_item(200, k[1:0], k == 7, k[0], k[1], k[2]));
        send_item(pack_item(150, NODE_SLEEP, 0, 0, 1, 0));
        send_item(pack_item(100, NODE_SETUP, 0, 1, 0, 0));
        send_item(pack_item(75, NODE_SLEEP, 0, 0, 0, 1));
        send_item(pack_item(25, NODE_SETUP, 0, 0, 0, 0));

        // Random: mostly short intervals so the phases move a tick at a time.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            gaps_on = !(i >= 700 && i < 1000);
            pick = $urandom_range(0, 99);
            if (pick < 45) elapsed = $urandom_range(0, 60);
            else if (pick < 75) elapsed = $urandom_range(40, 220);
            else if (pick < 92) elapsed = $urandom_range(0, 1023);
            else elapsed = ($urandom_range(0, 1) != 0) ? 1023 : 0;
            node = 2'($urandom_range(0, 3));
            send_item(pack_item(elapsed, node, $urandom_range(0, 99) < 15,
                                $urandom_range(0, 99) < 40, $urandom_range(0, 99) < 50,
                                $urandom_range(0, 99) < 30));
        end
        s_tvalid <= 1'b0;
        gaps_on = 1'b1;

        // Drain the outstanding results, then allow for the block's latency.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/slpd_pkg.sv
src/slpd_tick_step.sv
src/status_led_pattern_driver_core.sv
tb/sv/status_led_pattern_driver_core_checker.sv
tb/sv/status_led_pattern_driver_core_test.sv
